### design/lcdpdw_pkg.sv
// Package for the LCD cursor and decimal writer: codes, control word, microcode ROM.
`timescale 1ns / 1ps
package lcdpdw_pkg;

  // Request operation codes
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_NUMBER = 2'd2;

  // Fixed byte values
  localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_LINE1     = 8'h80;
  localparam logic [7:0] CMD_LINE2     = 8'hC0;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;

  localparam int unsigned MaxDigits = 10;
  localparam logic [3:0]  MAX_DIGITS  = 4'(MaxDigits);
  localparam logic [3:0]  TOP_DIGIT   = 4'(MaxDigits - 1);

  // Powers of ten, wide enough to hold nine times the largest one
  localparam logic [33:0] DEC_W [MaxDigits] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000, 34'd1000000,
    34'd10000000, 34'd100000000, 34'd1000000000
  };

  // Program entry points
  localparam logic [2:0] PC_INIT   = 3'd0;
  localparam logic [2:0] PC_CHAR   = 3'd4;
  localparam logic [2:0] PC_NUMBER = 3'd6;

  typedef enum logic {
    EM_ALWAYS,
    EM_IF_PLT
  } emit_e;

  typedef enum logic [1:0] {
    BS_CONST,
    BS_CURSOR,
    BS_CHAR,
    BS_DIGIT
  } bsel_e;

  typedef enum logic [1:0] {
    LS_NO,
    LS_YES,
    LS_IF_CNT0,
    LS_IF_P0
  } last_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_END,
    JMP_END_IF_CNT0,
    JMP_LOOP_P
  } jump_e;

  // One control word per program step
  typedef struct packed {
    emit_e      emit;
    logic       rs;
    bsel_e      bsel;
    logic [7:0] lit;
    last_e      last_sel;
    jump_e      jump;
    logic       digit;
  } ctl_t;

  // Microcode ROM
  function automatic ctl_t ucode(input logic [2:0] pc);
    ctl_t c;
    c = '{EM_ALWAYS, 1'b0, BS_CONST, 8'h00, LS_YES, JMP_END, 1'b0};
    case (pc)
      3'd0: c = '{EM_ALWAYS, 1'b0, BS_CONST, CMD_FUNC_SET, LS_NO, JMP_NEXT, 1'b0};
      3'd1: c = '{EM_ALWAYS, 1'b0, BS_CONST, CMD_DISP_ON, LS_NO, JMP_NEXT, 1'b0};
      3'd2: c = '{EM_ALWAYS, 1'b0, BS_CONST, CMD_ENTRY, LS_NO, JMP_NEXT, 1'b0};
      3'd3: c = '{EM_ALWAYS, 1'b0, BS_CONST, CMD_CLEAR, LS_YES, JMP_END, 1'b0};
      3'd4: c = '{EM_ALWAYS, 1'b0, BS_CURSOR, 8'h00, LS_NO, JMP_NEXT, 1'b0};
      3'd5: c = '{EM_ALWAYS, 1'b1, BS_CHAR, 8'h00, LS_YES, JMP_END, 1'b0};
      3'd6: c = '{EM_ALWAYS, 1'b0, BS_CURSOR, 8'h00, LS_IF_CNT0, JMP_END_IF_CNT0, 1'b0};
      3'd7: c = '{EM_IF_PLT, 1'b1, BS_DIGIT, 8'h00, LS_IF_P0, JMP_LOOP_P, 1'b1};
      default: c = '{EM_ALWAYS, 1'b0, BS_CONST, 8'h00, LS_YES, JMP_END, 1'b0};
    endcase
    return c;
  endfunction

endpackage

### design/lcd_position_and_decimal_writer.sv
// Top level: microcoded sequencer that turns one request into LCD command and data words.
//
//  channel   direction  handshake               words
//  request   in         start_i while !busy_o   operation, second_line, column,
//                                               char_code, number, digit_count
//  result    out        strobe_o, one cycle     register_select, lcd_byte, last
//
// An accepted request runs one program step per cycle: initialise 4 steps, show character 2,
// show number 11 (cursor, then all ten decimal positions, sending the low digit_count of
// them), or 1 when digit_count is zero. busy_o is high through the steps and the next
// request is taken the cycle after the last step. Each word appears in the cycle after its step.
// Operation code 3 is taken and sends nothing. Reset clears the sequencer; the receiver cannot
// stall, so every word goes in its strobe cycle.
`timescale 1ns / 1ps
module lcd_position_and_decimal_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  operation_i,
  input  logic        second_line_i,
  input  logic [5:0]  column_i,
  input  logic [7:0]  char_code_i,
  input  logic [31:0] number_i,
  input  logic [3:0]  digit_count_i,
  output logic        busy_o,
  output logic        strobe_o,
  output logic        register_select_o,
  output logic [7:0]  lcd_byte_o,
  output logic        last_o
);

  localparam int unsigned NDig = lcdpdw_pkg::MaxDigits;

  // Sequencer state
  logic       running_q, running_d;
  logic [2:0] pc_q, pc_d;

  // Request operands
  logic [7:0]  cursor_q;
  logic [7:0]  char_q;
  logic [31:0] rem_q, rem_d;
  logic [3:0]  cnt_q;
  logic [3:0]  pos_q, pos_d;

  // Result word
  logic       strobe_q, strobe_d;
  logic       rs_q, rs_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  lcdpdw_pkg::ctl_t ctl;
  logic accept;
  logic cnt_zero, pos_zero, pos_lt;
  logic [7:0] cursor_d;
  logic [3:0] cnt_d;
  logic [2:0] entry_pc;
  logic       entry_ok;

  // Multiples of each power of ten, constant
  logic [33:0] mult_tab [NDig][NDig];
  for (genvar gp = 0; gp < NDig; gp++) begin : g_pow
    for (genvar gk = 0; gk < NDig; gk++) begin : g_mul
      assign mult_tab[gp][gk] = 34'(gk) * lcdpdw_pkg::DEC_W[gp];
    end
  end

  // Digit unit: one decimal position per cycle
  logic [NDig-2:0] ge;
  logic [3:0]      dig;
  always_comb begin
    for (int k = 1; k < NDig; k++) begin
      ge[k-1] = {2'b00, rem_q} >= mult_tab[pos_q][k];
    end
    dig = 4'($countones(ge));
  end

  assign accept = start_i && !busy_o;
  assign ctl    = lcdpdw_pkg::ucode(pc_q);

  assign cnt_zero = (cnt_q == 4'd0);
  assign pos_zero = (pos_q == 4'd0);
  assign pos_lt   = (pos_q < cnt_q);

  // Decode the request at accept
  always_comb begin
    cursor_d = (second_line_i ? lcdpdw_pkg::CMD_LINE2 : lcdpdw_pkg::CMD_LINE1)
               | ({2'b00, column_i} - 8'd1);
    cnt_d    = (digit_count_i > lcdpdw_pkg::MAX_DIGITS) ? lcdpdw_pkg::MAX_DIGITS
                                                        : digit_count_i;
    entry_ok = 1'b1;
    case (operation_i)
      lcdpdw_pkg::OP_INIT:   entry_pc = lcdpdw_pkg::PC_INIT;
      lcdpdw_pkg::OP_CHAR:   entry_pc = lcdpdw_pkg::PC_CHAR;
      lcdpdw_pkg::OP_NUMBER: entry_pc = lcdpdw_pkg::PC_NUMBER;
      default: begin
        entry_pc = lcdpdw_pkg::PC_INIT;
        entry_ok = 1'b0;
      end
    endcase
  end

  // Execute the current control word
  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    strobe_d  = 1'b0;
    rs_d      = ctl.rs;
    last_d    = 1'b0;

    case (ctl.bsel)
      lcdpdw_pkg::BS_CONST:  byte_d = ctl.lit;
      lcdpdw_pkg::BS_CURSOR: byte_d = cursor_q;
      lcdpdw_pkg::BS_CHAR:   byte_d = char_q;
      lcdpdw_pkg::BS_DIGIT:  byte_d = lcdpdw_pkg::ASCII_ZERO + {4'h0, dig};
      default:               byte_d = ctl.lit;
    endcase

    if (running_q) begin
      // Send a word when the step asks for one
      case (ctl.emit)
        lcdpdw_pkg::EM_ALWAYS: strobe_d = 1'b1;
        lcdpdw_pkg::EM_IF_PLT: strobe_d = pos_lt;
        default:               strobe_d = 1'b1;
      endcase

      case (ctl.last_sel)
        lcdpdw_pkg::LS_NO:      last_d = 1'b0;
        lcdpdw_pkg::LS_YES:     last_d = 1'b1;
        lcdpdw_pkg::LS_IF_CNT0: last_d = cnt_zero;
        lcdpdw_pkg::LS_IF_P0:   last_d = pos_zero;
        default:                last_d = 1'b0;
      endcase

      // Drop the top digit and move to the next position
      if (ctl.digit) begin
        rem_d = rem_q - mult_tab[pos_q][dig][31:0];
        pos_d = pos_q - 4'd1;
      end

      case (ctl.jump)
        lcdpdw_pkg::JMP_NEXT: pc_d = pc_q + 3'd1;
        lcdpdw_pkg::JMP_END:  running_d = 1'b0;
        lcdpdw_pkg::JMP_END_IF_CNT0: begin
          if (cnt_zero) begin
            running_d = 1'b0;
          end else begin
            pc_d = pc_q + 3'd1;
          end
        end
        lcdpdw_pkg::JMP_LOOP_P: begin
          if (pos_zero) begin
            running_d = 1'b0;
          end
        end
        default: running_d = 1'b0;
      endcase
    end else if (accept) begin
      running_d = entry_ok;
      pc_d      = entry_pc;
      rem_d     = number_i;
      pos_d     = lcdpdw_pkg::TOP_DIGIT;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= lcdpdw_pkg::PC_INIT;
      strobe_q  <= 1'b0;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
      strobe_q  <= strobe_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    rs_q   <= rs_d;
    byte_q <= byte_d;
    last_q <= last_d;
    if (accept) begin
      cursor_q <= cursor_d;
      char_q   <= char_code_i;
      cnt_q    <= cnt_d;
    end
  end

  assign busy_o            = running_q;
  assign strobe_o          = strobe_q;
  assign register_select_o = rs_q;
  assign lcd_byte_o        = byte_q;
  assign last_o            = last_q;

  // Checks
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !running_q)
    else $error("last word while program still running");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q && ctl.digit |-> dig <= 4'd9)
    else $error("digit unit produced a value above nine");

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q && ctl.digit && !pos_zero |=> pos_q == $past(pos_q) - 4'd1)
    else $error("digit position did not advance");

  a_run_starts_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(running_q) |-> $past(start_i))
    else $error("program started without a request");

endmodule
